### rtl/core/bcssm_pkg.sv
// ----------------------------------------------------------------------------
// bcssm_pkg
// Types, codes and decode tables shared by the four-digit counter core and
// its channel interfaces.
// ----------------------------------------------------------------------------
package bcssm_pkg;

	localparam int unsigned COUNT_W = 14;
	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned SEL_W   = 4;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned WIDE_W  = 18;
	localparam int unsigned PROD_W  = 32;
	localparam int unsigned RECIP_W = 16;
	localparam int unsigned SHIFT_W = 5;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [WIDE_W-1:0]  wide_t;
	typedef logic [1:0]         scan_t;
	typedef logic [SEL_W-1:0]   sel_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SEG_W-1:0]   seg_t;
	typedef logic [RECIP_W-1:0] recip_t;
	typedef logic [SHIFT_W-1:0] shift_t;
	typedef logic [PROD_W-1:0]  prod_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 3'd0,
		FUNC_INC    = 3'd1,
		FUNC_DOUBLE = 3'd2,
		FUNC_TIMES  = 3'd3,
		FUNC_DIV    = 3'd4,
		FUNC_LOAD   = 3'd5
	} func_t;

	localparam wide_t LIMIT = wide_t'(9999);

	// x / 10 for any 14-bit x
	localparam recip_t DIV10_M = recip_t'(52429);
	localparam shift_t DIV10_S = shift_t'(19);

	localparam scan_t SCAN_ONES      = 2'd0;
	localparam scan_t SCAN_TENS      = 2'd1;
	localparam scan_t SCAN_HUNDREDS  = 2'd2;
	localparam scan_t SCAN_THOUSANDS = 2'd3;

	function automatic sel_t sel_code(input scan_t pos);
		sel_t s;
		unique case (pos)
			SCAN_ONES:      s = 4'b0111;
			SCAN_TENS:      s = 4'b1011;
			SCAN_HUNDREDS:  s = 4'b1101;
			SCAN_THOUSANDS: s = 4'b1110;
		endcase
		return s;
	endfunction

	// reciprocal for count / 10^pos
	function automatic recip_t recip_lo(input scan_t pos);
		recip_t m;
		unique case (pos)
			SCAN_ONES:      m = recip_t'(1);
			SCAN_TENS:      m = recip_t'(52429);
			SCAN_HUNDREDS:  m = recip_t'(5243);
			SCAN_THOUSANDS: m = recip_t'(8389);
		endcase
		return m;
	endfunction

	function automatic shift_t shift_lo(input scan_t pos);
		shift_t s;
		unique case (pos)
			SCAN_ONES:      s = shift_t'(0);
			SCAN_TENS:      s = shift_t'(19);
			SCAN_HUNDREDS:  s = shift_t'(19);
			SCAN_THOUSANDS: s = shift_t'(23);
		endcase
		return s;
	endfunction

	// reciprocal for count / 10^(pos+1)
	function automatic recip_t recip_hi(input scan_t pos);
		recip_t m;
		unique case (pos)
			SCAN_ONES:      m = recip_t'(52429);
			SCAN_TENS:      m = recip_t'(5243);
			SCAN_HUNDREDS:  m = recip_t'(8389);
			SCAN_THOUSANDS: m = recip_t'(53688);
		endcase
		return m;
	endfunction

	function automatic shift_t shift_hi(input scan_t pos);
		shift_t s;
		unique case (pos)
			SCAN_ONES:      s = shift_t'(19);
			SCAN_TENS:      s = shift_t'(19);
			SCAN_HUNDREDS:  s = shift_t'(23);
			SCAN_THOUSANDS: s = shift_t'(29);
		endcase
		return s;
	endfunction

	// bit 0 is segment a
	function automatic seg_t seg_code(input digit_t d);
		seg_t s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7C;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h67;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

### rtl/core/bcssm_if.sv
// ----------------------------------------------------------------------------
// bcssm_if
// Valid/ready channels of the counter core: command items in, display
// items out.
// ----------------------------------------------------------------------------
interface bcssm_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [bcssm_pkg::FUNC_W-1:0]    func;
	bcssm_pkg::count_t               load_value;

	modport source (output valid, output func, output load_value, input ready);
	modport sink   (input valid, input func, input load_value, output ready);
endinterface

interface bcssm_disp_if;
	logic                 valid;
	logic                 ready;
	bcssm_pkg::count_t    count_value;
	bcssm_pkg::sel_t      digit_select;
	bcssm_pkg::digit_t    digit_value;
	bcssm_pkg::seg_t      segments;

	modport source (output valid, output count_value, output digit_select,
		output digit_value, output segments, input ready);
	modport sink   (input valid, input count_value, input digit_select,
		input digit_value, input segments, output ready);
endinterface

### rtl/core/button_counter_seven_segment_mux_core.sv
// ----------------------------------------------------------------------------
// button_counter_seven_segment_mux_core
// Four-digit decimal counter with display scan and seven-segment decode.
// ----------------------------------------------------------------------------
// Takes one command item per cycle while the pipeline is not stalled, and gives
// one display item for each, in order. The display item is valid on the output
// once it reaches stage 3, and is taken at the first edge after that with ready high.
// Stage 1 registers the command, stage 2 holds the updated count and scan
// position (the counter update, including the divide by ten through a
// reciprocal multiply, is combinational, so items follow back to back),
// and stage 3 holds the decoded digit, its select pattern and segment code.
// A stage holds its item only while every stage after it is full and the
// display side holds ready low; empty stages are filled without waiting.
module button_counter_seven_segment_mux_core (
	input  logic                 clk,
	input  logic                 arst_n,
	bcssm_cmd_if.sink            cmd,
	bcssm_disp_if.source         disp
);

	logic                         valid_s1;
	logic [bcssm_pkg::FUNC_W-1:0] func_s1;
	bcssm_pkg::count_t            load_s1;

	logic                         valid_s2;
	bcssm_pkg::count_t            count_s2;
	bcssm_pkg::scan_t             scan_s2;

	logic                         valid_s3;
	bcssm_pkg::count_t            count_s3;
	bcssm_pkg::sel_t              sel_s3;
	bcssm_pkg::digit_t            digit_s3;
	bcssm_pkg::seg_t              seg_s3;

	bcssm_pkg::count_t            counter_q;
	bcssm_pkg::scan_t             scan_q;

	logic                         adv1;
	logic                         adv2;
	logic                         adv3;

	bcssm_pkg::count_t            floored;
	bcssm_pkg::prod_t             div_prod;
	bcssm_pkg::wide_t             wide_next;
	bcssm_pkg::count_t            count_next;
	bcssm_pkg::scan_t             scan_next;

	bcssm_pkg::prod_t             prod_lo;
	bcssm_pkg::prod_t             prod_hi;
	bcssm_pkg::count_t            quot_lo;
	bcssm_pkg::count_t            quot_hi;
	bcssm_pkg::count_t            digit_full;
	bcssm_pkg::digit_t            digit_next;

	assign adv3      = !valid_s3 || disp.ready;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign cmd.ready = adv1;

	// counter update
	always_comb begin
		floored   = (counter_q == '0) ? bcssm_pkg::count_t'(1) : counter_q;
		div_prod  = bcssm_pkg::prod_t'(floored) * bcssm_pkg::prod_t'(bcssm_pkg::DIV10_M);
		wide_next = bcssm_pkg::wide_t'(counter_q);
		scan_next = scan_q;
		unique case (bcssm_pkg::func_t'(func_s1))
			bcssm_pkg::FUNC_TICK:   scan_next = scan_q + 2'd1;
			bcssm_pkg::FUNC_INC:    wide_next = bcssm_pkg::wide_t'(counter_q) + 18'd1;
			bcssm_pkg::FUNC_DOUBLE: wide_next = bcssm_pkg::wide_t'(floored) << 1;
			bcssm_pkg::FUNC_TIMES:  wide_next = (bcssm_pkg::wide_t'(floored) << 3)
				+ (bcssm_pkg::wide_t'(floored) << 1);
			bcssm_pkg::FUNC_DIV:    wide_next =
				bcssm_pkg::wide_t'(div_prod >> bcssm_pkg::DIV10_S);
			bcssm_pkg::FUNC_LOAD:   wide_next = bcssm_pkg::wide_t'(load_s1);
			default:                wide_next = bcssm_pkg::wide_t'(counter_q);
		endcase
		count_next = (wide_next >= bcssm_pkg::LIMIT) ? '0 : wide_next[bcssm_pkg::COUNT_W-1:0];
	end

	// digit at the scan position: count / 10^p minus ten times count / 10^(p+1)
	always_comb begin
		prod_lo    = bcssm_pkg::prod_t'(count_s2)
			* bcssm_pkg::prod_t'(bcssm_pkg::recip_lo(scan_s2));
		prod_hi    = bcssm_pkg::prod_t'(count_s2)
			* bcssm_pkg::prod_t'(bcssm_pkg::recip_hi(scan_s2));
		quot_lo    = bcssm_pkg::count_t'(prod_lo >> bcssm_pkg::shift_lo(scan_s2));
		quot_hi    = bcssm_pkg::count_t'(prod_hi >> bcssm_pkg::shift_hi(scan_s2));
		digit_full = quot_lo - (quot_hi << 3) - (quot_hi << 1);
		digit_next = digit_full[bcssm_pkg::DIGIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			counter_q <= '0;
			scan_q    <= bcssm_pkg::SCAN_ONES;
		end else begin
			if (adv1) begin
				valid_s1 <= cmd.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					counter_q <= count_next;
					scan_q    <= scan_next;
				end
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			func_s1 <= cmd.func;
			load_s1 <= cmd.load_value;
		end
		if (adv2) begin
			count_s2 <= count_next;
			scan_s2  <= scan_next;
		end
		if (adv3) begin
			count_s3 <= count_s2;
			sel_s3   <= bcssm_pkg::sel_code(scan_s2);
			digit_s3 <= digit_next;
			seg_s3   <= bcssm_pkg::seg_code(digit_next);
		end
	end

	assign disp.valid        = valid_s3;
	assign disp.count_value  = count_s3;
	assign disp.digit_select = sel_s3;
	assign disp.digit_value  = digit_s3;
	assign disp.segments     = seg_s3;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the four-digit counter core and checks every
// display item against written-out values or an independent model of the
// count, scan and decode; both channels idle at random outside a steady run.
// ----------------------------------------------------------------------------
module testbench;
	import bcssm_pkg::*;

	localparam int unsigned COUNT_LIMIT  = 9999;
	localparam int unsigned RANDOM_ITEMS = 1425;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned IDLE_PCT     = 29;
	localparam int unsigned STEADY_FIRST = 500;
	localparam int unsigned STEADY_LAST  = 850;
	localparam int unsigned PRINT_CAP    = 40;

	// codes the block leaves without effect
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	localparam sel_t SEL_PATTERN [4] = '{4'b0111, 4'b1011, 4'b1101, 4'b1110};
	localparam seg_t SEG_PATTERN [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7C, 7'h07, 7'h7F, 7'h67};
	localparam int unsigned PLACE [4] = '{1, 10, 100, 1000};

	typedef struct packed {
		count_t count;
		sel_t   sel;
		digit_t dval;
		seg_t   seg;
	} disp_t;

	typedef struct packed {
		logic [FUNC_W-1:0] op;
		count_t            load;
		logic              fixed;
		disp_t             want;
	} row_t;

	localparam int unsigned N_ROWS = 25;
	localparam disp_t SHOW_ZERO = '{14'd0, 4'b1011, 4'd0, 7'h3F};
	localparam disp_t NONE      = '0;

	// fixed rows have their result written out; the rest use the model
	localparam row_t DIRECTED [N_ROWS] = '{
		'{FUNC_TICK,     14'd0,     1'b1, SHOW_ZERO},
		'{FUNC_LOAD,     14'd9998,  1'b1, '{14'd9998, 4'b1011, 4'd9, 7'h67}},
		'{FUNC_INC,      14'd0,     1'b1, SHOW_ZERO},
		'{FUNC_DOUBLE,   14'd0,     1'b0, NONE},
		'{FUNC_TIMES,    14'd0,     1'b0, NONE},
		'{FUNC_DIV,      14'd0,     1'b0, NONE},
		'{FUNC_LOAD,     14'd0,     1'b1, SHOW_ZERO},
		'{FUNC_DIV,      14'd16383, 1'b0, NONE},
		'{FUNC_TIMES,    14'd0,     1'b0, NONE},
		'{FUNC_LOAD,     14'd16383, 1'b1, SHOW_ZERO},
		'{FUNC_LOAD,     14'd9999,  1'b1, SHOW_ZERO},
		'{FUNC_LOAD,     14'd5000,  1'b0, NONE},
		'{FUNC_DOUBLE,   14'd0,     1'b0, NONE},
		'{FUNC_LOAD,     14'd1000,  1'b0, NONE},
		'{FUNC_TIMES,    14'd0,     1'b0, NONE},
		'{FUNC_SPARE_LO, 14'd16383, 1'b0, NONE},
		'{FUNC_SPARE_HI, 14'd0,     1'b0, NONE},
		'{FUNC_LOAD,     14'd6969,  1'b0, NONE},
		'{FUNC_TICK,     14'd0,     1'b0, NONE},
		'{FUNC_TICK,     14'd0,     1'b0, NONE},
		'{FUNC_TICK,     14'd0,     1'b0, NONE},
		'{FUNC_LOAD,     14'd8765,  1'b0, NONE},
		'{FUNC_TICK,     14'd0,     1'b0, NONE},
		'{FUNC_TICK,     14'd0,     1'b0, NONE},
		'{FUNC_TICK,     14'd0,     1'b0, NONE}
	};

	logic clk;
	logic arst_n;

	bcssm_cmd_if  cmd ();
	bcssm_disp_if disp ();

	button_counter_seven_segment_mux_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.disp   (disp)
	);

	row_t        pending_q[$];
	disp_t       display_q[$];
	row_t        on_bus;
	count_t      count_q;
	scan_t       scan_q;
	bit          steady;
	int unsigned items_sent;
	int unsigned items_in;
	int unsigned items_out;
	int unsigned items_total;
	int unsigned wraps;
	int unsigned errors;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d of %0d items in, %0d out",
			cycles, items_in, items_total, items_out);
		$display("testbench: errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("mismatch: %s", msg);
		errors++;
	endtask

	// advances the model by one command and gives the display it implies
	function automatic disp_t predict_display(input logic [FUNC_W-1:0] op,
		input count_t load);
		int unsigned c;
		disp_t r;
		c = count_q;
		case (op)
			FUNC_TICK:   scan_q = scan_q + 2'd1;
			FUNC_INC:    c = c + 1;
			FUNC_DOUBLE: c = ((c == 0) ? 1 : c) * 2;
			FUNC_TIMES:  c = ((c == 0) ? 1 : c) * 10;
			FUNC_DIV:    c = ((c == 0) ? 1 : c) / 10;
			FUNC_LOAD:   c = load;
			default:     ;
		endcase
		if (c >= COUNT_LIMIT) begin
			c = 0;
			wraps++;
		end
		count_q = count_t'(c);
		r.count = count_q;
		r.sel   = SEL_PATTERN[scan_q];
		r.dval  = digit_t'((c / PLACE[scan_q]) % 10);
		r.seg   = SEG_PATTERN[r.dval];
		return r;
	endfunction

	// command side
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else if (!cmd.valid || cmd.ready) begin
			steady = (items_sent >= STEADY_FIRST) && (items_sent < STEADY_LAST);
			if (pending_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				row_t row;
				row = pending_q.pop_front();
				on_bus         <= row;
				cmd.valid      <= 1'b1;
				cmd.func       <= row.op;
				cmd.load_value <= row.load;
				items_sent++;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// display side
	always @(posedge clk) begin
		if (!arst_n) begin
			disp.ready <= 1'b0;
		end else begin
			disp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				disp_t guess;
				guess = predict_display(cmd.func, cmd.load_value);
				display_q.push_back(on_bus.fixed ? on_bus.want : guess);
				items_in++;
			end
			if (disp.valid && disp.ready) begin
				if (display_q.size() == 0) begin
					report_mismatch($sformatf("item %0d arrived with nothing pending",
						items_out));
				end else begin
					disp_t want;
					want = display_q.pop_front();
					if (disp.count_value !== want.count)
						report_mismatch($sformatf("item %0d count_value %0d, wanted %0d",
							items_out, disp.count_value, want.count));
					if (disp.digit_select !== want.sel)
						report_mismatch($sformatf("item %0d digit_select %b, wanted %b",
							items_out, disp.digit_select, want.sel));
					if (disp.digit_value !== want.dval)
						report_mismatch($sformatf("item %0d digit_value %0d, wanted %0d",
							items_out, disp.digit_value, want.dval));
					if (disp.segments !== want.seg)
						report_mismatch($sformatf("item %0d segments %h, wanted %h",
							items_out, disp.segments, want.seg));
				end
				items_out++;
			end
		end
	end

	initial begin
		row_t row;
		int unsigned pick;
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.func       = '0;
		cmd.load_value = '0;
		disp.ready     = 1'b0;
		count_q        = '0;
		scan_q         = SCAN_ONES;
		steady         = 1'b0;
		on_bus         = '0;
		items_sent     = 0;
		items_in       = 0;
		items_out      = 0;
		wraps          = 0;
		errors         = 0;
		cycles         = 0;

		for (int i = 0; i < N_ROWS; i++)
			pending_q.push_back(DIRECTED[i]);

		// ordinary traffic mix, loads often near or past the limit
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			row.fixed = 1'b0;
			row.want  = '0;
			row.load  = count_t'($urandom_range(16383));
			pick = $urandom_range(99);
			if (pick < 25)
				row.op = FUNC_TICK;
			else if (pick < 45)
				row.op = FUNC_INC;
			else if (pick < 55)
				row.op = FUNC_DOUBLE;
			else if (pick < 65)
				row.op = FUNC_TIMES;
			else if (pick < 75)
				row.op = FUNC_DIV;
			else if (pick < 94) begin
				row.op = FUNC_LOAD;
				case ($urandom_range(3))
					0: row.load = count_t'($urandom_range(9998));
					1: row.load = count_t'($urandom_range(16383, 9990));
					2: row.load = count_t'($urandom_range(999));
					default: ;
				endcase
			end else
				row.op = $urandom_range(1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
			pending_q.push_back(row);
		end
		items_total = pending_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (items_in == items_total);
		wait (display_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (display_q.size() != 0)
			report_mismatch($sformatf("%0d display items never arrived", display_q.size()));

		$display("%0d command items (%0d directed, %0d random), %0d display items checked",
			items_in, N_ROWS, RANDOM_ITEMS, items_out);
		$display("%0d steps wrapped the count to zero, %0d mismatches", wraps, errors);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
